/* sv/brs_pkg.sv */
// Shared types, codes, constants and the ramp table for the backlight ramp sequencer.
`default_nettype none
package brs_pkg;

  localparam int TableDepthDef = 44;
  localparam int IdxW          = 6;
  localparam int LuxW          = 24;
  localparam int BrightW       = 8;
  localparam int DelayW        = 10;
  localparam int CfgIdxW       = 2;
  localparam int CfgDataW      = 24;

  localparam logic [LuxW-1:0]    LuxThresholdRst   = 24'd512;
  localparam logic [BrightW-1:0] RampCeilingRst    = 8'd30;
  localparam logic [DelayW-1:0]  StartDelayRst     = 10'd100;
  localparam logic [DelayW-1:0]  RampIntervalRst   = 10'd75;

  typedef enum logic [2:0] {
    OpStart = 3'd0,
    OpStop  = 3'd1,
    OpLight = 3'd2,
    OpDelay = 3'd3,
    OpTick  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ActNone     = 2'd0,
    ActArmDelay = 2'd1,
    ActSet      = 2'd2,
    ActEnd      = 2'd3
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLuxThreshold = 2'd0,
    CfgRampCeiling  = 2'd1,
    CfgStartDelay   = 2'd2,
    CfgRampInterval = 2'd3
  } cfg_reg_e;

  typedef enum logic [5:0] {
    PhInit      = 6'b000001,
    PhWaitBoth  = 6'b000010,
    PhWaitLight = 6'b000100,
    PhWaitDelay = 6'b001000,
    PhRamp      = 6'b010000,
    PhEnd       = 6'b100000
  } phase_e;

  typedef struct packed {
    action_e             action;
    logic [BrightW-1:0]  value;
    logic [DelayW-1:0]   delay;
    logic [2:0]          phase;
  } res_t;

  function automatic logic [2:0] phase_code(phase_e ph);
    logic [2:0] code;
    unique case (ph)
      PhInit:      code = 3'd0;
      PhWaitBoth:  code = 3'd1;
      PhWaitLight: code = 3'd2;
      PhWaitDelay: code = 3'd3;
      PhRamp:      code = 3'd4;
      PhEnd:       code = 3'd5;
      default:     code = 3'd0;
    endcase
    return code;
  endfunction

  // Stock brightness steps; everything past the stock entries reads as full scale.
  function automatic logic [BrightW-1:0] ramp_entry(logic [IdxW-1:0] idx);
    logic [BrightW-1:0] v;
    case (idx)
      6'd0:  v = 8'd4;    6'd1:  v = 8'd4;    6'd2:  v = 8'd5;    6'd3:  v = 8'd5;
      6'd4:  v = 8'd6;    6'd5:  v = 8'd6;    6'd6:  v = 8'd7;    6'd7:  v = 8'd8;
      6'd8:  v = 8'd9;    6'd9:  v = 8'd9;    6'd10: v = 8'd10;   6'd11: v = 8'd11;
      6'd12: v = 8'd13;   6'd13: v = 8'd14;   6'd14: v = 8'd15;   6'd15: v = 8'd17;
      6'd16: v = 8'd18;   6'd17: v = 8'd20;   6'd18: v = 8'd22;   6'd19: v = 8'd24;
      6'd20: v = 8'd27;   6'd21: v = 8'd30;   6'd22: v = 8'd33;   6'd23: v = 8'd36;
      6'd24: v = 8'd39;   6'd25: v = 8'd43;   6'd26: v = 8'd48;   6'd27: v = 8'd52;
      6'd28: v = 8'd58;   6'd29: v = 8'd63;   6'd30: v = 8'd70;   6'd31: v = 8'd77;
      6'd32: v = 8'd84;   6'd33: v = 8'd93;   6'd34: v = 8'd102;  6'd35: v = 8'd112;
      6'd36: v = 8'd124;  6'd37: v = 8'd136;  6'd38: v = 8'd150;  6'd39: v = 8'd166;
      6'd40: v = 8'd181;  6'd41: v = 8'd199;  6'd42: v = 8'd219;  6'd43: v = 8'd241;
      default: v = 8'd255;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* sv/backlight_ramp_sequencer.sv */
// Backlight ramp sequencer: event-driven phase machine with ramp table lookup.
// A result is registered into the output or skid register on its input transfer.
// Throughput: one item per cycle while the skid register is empty; a two-deep
// output stage (result plus skid) keeps input transfers going while a result waits.
// Reset: phase init, stored lux and ramp index zero, registers at reset values,
// no result pending.
`default_nettype none
module backlight_ramp_sequencer #(
  parameter int TABLE_DEPTH = brs_pkg::TableDepthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,

  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [brs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [brs_pkg::CfgDataW-1:0]  cfg_data_i,

  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [2:0]                    op_i,
  input  wire logic [brs_pkg::LuxW-1:0]      lux_i,
  input  wire logic [brs_pkg::BrightW-1:0]   current_brightness_i,
  input  wire logic                          brightness_valid_i,

  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [1:0]                         action_o,
  output logic [brs_pkg::BrightW-1:0]        brightness_value_o,
  output logic [brs_pkg::DelayW-1:0]         timer_delay_ms_o,
  output logic [2:0]                         phase_now_o
);

  localparam int IdxW = brs_pkg::IdxW;
  localparam logic [IdxW-1:0] DepthL = IdxW'(TABLE_DEPTH);

  // configuration registers
  logic [brs_pkg::LuxW-1:0]    lux_thr_q;
  logic [brs_pkg::BrightW-1:0] ceiling_q;
  logic [brs_pkg::DelayW-1:0]  start_dly_q;
  logic [brs_pkg::DelayW-1:0]  ramp_int_q;

  brs_pkg::phase_e             phase_q, phase_d;
  logic [brs_pkg::LuxW-1:0]    lux_q, lux_d;
  logic [IdxW-1:0]             idx_q, idx_d;

  brs_pkg::res_t               res;
  brs_pkg::res_t               out_q, skid_q;
  logic                        out_vld_q, skid_vld_q;

  logic                        in_xfer;
  logic                        out_xfer;
  logic [63:0]                 le_vec;
  logic [IdxW-1:0]             begin_idx;
  logic [IdxW-1:0]             step_idx;
  logic [brs_pkg::BrightW-1:0] step_val;
  logic                        begin_req;
  logic                        step_req;
  brs_pkg::phase_e             phase_n;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !skid_vld_q;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_xfer    = out_vld_q && out_ready_i;

  // Table is nondecreasing, so the first entry above the brightness sits at
  // the count of entries at or below it.
  always_comb begin
    for (int i = 0; i < 64; i++) begin
      le_vec[i] = (i < TABLE_DEPTH) &&
                  (brs_pkg::ramp_entry(IdxW'(i)) <= current_brightness_i);
    end
    begin_idx = IdxW'($countones(le_vec));
  end

  always_comb begin
    phase_n    = phase_q;
    lux_d      = lux_q;
    idx_d      = idx_q;
    begin_req  = 1'b0;
    step_req   = 1'b0;
    step_idx   = idx_q;
    step_val   = '0;
    res.action = brs_pkg::ActNone;
    res.value  = '0;
    res.delay  = '0;

    case (op_i)
      brs_pkg::OpStart: begin
        phase_n    = brs_pkg::PhWaitBoth;
        res.action = brs_pkg::ActArmDelay;
        res.delay  = start_dly_q;
      end
      brs_pkg::OpStop: begin
        if (phase_q != brs_pkg::PhInit && phase_q != brs_pkg::PhEnd) begin
          phase_n    = brs_pkg::PhEnd;
          res.action = brs_pkg::ActEnd;
        end
      end
      brs_pkg::OpLight: begin
        lux_d = lux_i;
        if (phase_q == brs_pkg::PhWaitBoth) begin
          phase_n = brs_pkg::PhWaitDelay;
        end else if (phase_q == brs_pkg::PhWaitLight) begin
          begin_req = 1'b1;
        end
      end
      brs_pkg::OpDelay: begin
        if (phase_q == brs_pkg::PhWaitBoth) begin
          phase_n = brs_pkg::PhWaitLight;
        end else if (phase_q == brs_pkg::PhWaitDelay) begin
          begin_req = 1'b1;
        end
      end
      brs_pkg::OpTick: begin
        if (phase_q == brs_pkg::PhRamp) begin
          step_req = 1'b1;
        end
      end
      default: ;
    endcase

    // lux_d holds the sample carried by this item on OpLight, else the stored sample
    if (begin_req) begin
      phase_n = brs_pkg::PhRamp;
      if (!(lux_d < lux_thr_q)) begin
        phase_n    = brs_pkg::PhEnd;
        res.action = brs_pkg::ActEnd;
      end else if (brightness_valid_i) begin
        idx_d    = begin_idx;
        step_idx = begin_idx;
        step_req = 1'b1;
      end
    end

    if (step_req && step_idx < DepthL) begin
      step_val = brs_pkg::ramp_entry(step_idx);
      idx_d    = step_idx + 1'b1;
      if (step_val <= ceiling_q) begin
        res.action = brs_pkg::ActSet;
        res.value  = step_val;
        res.delay  = ramp_int_q;
      end
    end

    phase_d   = phase_n;
    res.phase = brs_pkg::phase_code(phase_n);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lux_thr_q   <= brs_pkg::LuxThresholdRst;
      ceiling_q   <= brs_pkg::RampCeilingRst;
      start_dly_q <= brs_pkg::StartDelayRst;
      ramp_int_q  <= brs_pkg::RampIntervalRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        brs_pkg::CfgLuxThreshold: lux_thr_q   <= cfg_data_i;
        brs_pkg::CfgRampCeiling:  ceiling_q   <= cfg_data_i[brs_pkg::BrightW-1:0];
        brs_pkg::CfgStartDelay:   start_dly_q <= cfg_data_i[brs_pkg::DelayW-1:0];
        brs_pkg::CfgRampInterval: ramp_int_q  <= cfg_data_i[brs_pkg::DelayW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= brs_pkg::PhInit;
      lux_q   <= '0;
      idx_q   <= '0;
    end else if (in_xfer) begin
      phase_q <= phase_d;
      lux_q   <= lux_d;
      idx_q   <= idx_d;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (in_xfer) begin
      if (!out_vld_q || out_ready_i) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (out_xfer) begin
      if (skid_vld_q) begin
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      if (!out_vld_q || out_ready_i) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (out_xfer && skid_vld_q) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign action_o           = out_q.action;
  assign brightness_value_o = out_q.value;
  assign timer_delay_ms_o   = out_q.delay;
  assign phase_now_o        = out_q.phase;

endmodule
`default_nettype wire
